### rtl/acci_pkg.sv
`default_nettype none
package acci_pkg;

	// Geometry and request widths.
	localparam int LBA_BITS   = 28;
	localparam int HPC_W      = 5;
	localparam int SPT_W      = 6;
	localparam int PC_W       = HPC_W + SPT_W;
	localparam int CYL_W      = 16;
	localparam int COUNT_W    = 8;
	localparam int CMD_W      = 8;
	localparam int DIR_W      = 2;
	localparam int DW_W       = 15;
	localparam int IDX_W      = 3;
	localparam int VAL_W      = 8;
	localparam int DWORD_SHIFT = 7;

	// Cylinder divider: quotient bits resolved per pipeline stage.
	localparam int BPS        = 4;
	localparam int DIV_STAGES = (LBA_BITS + BPS - 1) / BPS;
	localparam int LBA_PAD    = DIV_STAGES * BPS;

	// Queue between the conversion pipeline and the register sequencer.
	localparam int QDEPTH  = 8;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Configuration port.
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_OP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OP = 2'd3;

	localparam logic [HPC_W-1:0] HEADS_RST    = 5'd16;
	localparam logic [SPT_W-1:0] SPT_RST      = 6'd63;
	localparam logic [CMD_W-1:0] READ_OP_RST  = 8'h20;
	localparam logic [CMD_W-1:0] WRITE_OP_RST = 8'h30;

	// Task file register indexes.
	localparam logic [IDX_W-1:0] REG_COUNT    = 3'd2;
	localparam logic [IDX_W-1:0] REG_SECTOR   = 3'd3;
	localparam logic [IDX_W-1:0] REG_CYL_LOW  = 3'd4;
	localparam logic [IDX_W-1:0] REG_CYL_HIGH = 3'd5;
	localparam logic [IDX_W-1:0] REG_DRV_HEAD = 3'd6;
	localparam logic [IDX_W-1:0] REG_COMMAND  = 3'd7;

	localparam logic [VAL_W-1:0] DRV_HEAD_BASE = 8'hA0;

	localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_READ  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_WRITE = 2'd2;

	typedef struct packed {
		logic [HPC_W-1:0] heads;
		logic [SPT_W-1:0] spt;
		logic [CMD_W-1:0] read_op;
		logic [CMD_W-1:0] write_op;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [CMD_W-1:0]   cmd;
		logic [DIR_W-1:0]   dir;
		logic [CYL_W-1:0]   cyl;
		logic [HPC_W-1:0]   head;
		logic [SPT_W-1:0]   sect;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
		logic [DIR_W-1:0] dir;
		logic [DW_W-1:0]  dwords;
		logic             last;
	} wr_t;

endpackage
`default_nettype wire

### rtl/acci_regs.sv
`default_nettype none
module acci_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [acci_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [acci_pkg::PDATA_W-1:0]  pwdata,
	output logic      [acci_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output acci_pkg::cfg_t                     cfg
);

	acci_pkg::cfg_t                      cfg_q;
	logic [acci_pkg::CFG_IDX_W-1:0]      sel;
	logic                                wr_en;

	assign sel    = paddr[acci_pkg::PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heads    <= acci_pkg::HEADS_RST;
			cfg_q.spt      <= acci_pkg::SPT_RST;
			cfg_q.read_op  <= acci_pkg::READ_OP_RST;
			cfg_q.write_op <= acci_pkg::WRITE_OP_RST;
		end else if (wr_en) begin
			case (sel)
				acci_pkg::CFG_HEADS:    cfg_q.heads    <= pwdata[acci_pkg::HPC_W-1:0];
				acci_pkg::CFG_SPT:      cfg_q.spt      <= pwdata[acci_pkg::SPT_W-1:0];
				acci_pkg::CFG_READ_OP:  cfg_q.read_op  <= pwdata[acci_pkg::CMD_W-1:0];
				acci_pkg::CFG_WRITE_OP: cfg_q.write_op <= pwdata[acci_pkg::CMD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (sel)
			acci_pkg::CFG_HEADS:    prdata = acci_pkg::PDATA_W'(cfg_q.heads);
			acci_pkg::CFG_SPT:      prdata = acci_pkg::PDATA_W'(cfg_q.spt);
			acci_pkg::CFG_READ_OP:  prdata = acci_pkg::PDATA_W'(cfg_q.read_op);
			acci_pkg::CFG_WRITE_OP: prdata = acci_pkg::PDATA_W'(cfg_q.write_op);
			default:                prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/acci_front.sv
`default_nettype none
module acci_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [acci_pkg::LBA_BITS-1:0]  block_address,
	input  wire logic [acci_pkg::COUNT_W-1:0]   sector_count,
	input  wire logic [acci_pkg::CMD_W-1:0]     command,
	input  wire acci_pkg::cfg_t                 cfg,
	input  wire logic                           q_pop,
	output logic                                req_valid,
	output acci_pkg::req_t                      req
);

	typedef struct packed {
		logic [acci_pkg::LBA_PAD-1:0] num;
		logic [acci_pkg::PC_W-1:0]    rem;
		logic [acci_pkg::CYL_W-1:0]   quo;
		logic [acci_pkg::COUNT_W-1:0] count;
		logic [acci_pkg::CMD_W-1:0]   cmd;
		logic [acci_pkg::DIR_W-1:0]   dir;
	} div_t;

	// One stage of the cylinder divider: BPS restoring steps.
	function automatic div_t div_stage(input div_t x, input logic [acci_pkg::PC_W-1:0] d);
		div_t                       y;
		logic [acci_pkg::PC_W:0]    t;
		logic [acci_pkg::BPS-1:0]   qb;
		logic                       ge;
		y  = x;
		qb = '0;
		for (int i = 0; i < acci_pkg::BPS; i++) begin
			t     = {y.rem, y.num[acci_pkg::LBA_PAD-1]};
			y.num = {y.num[acci_pkg::LBA_PAD-2:0], 1'b0};
			ge    = (t >= {1'b0, d});
			if (ge) begin
				t = t - {1'b0, d};
			end
			qb    = {qb[acci_pkg::BPS-2:0], ge};
			y.rem = t[acci_pkg::PC_W-1:0];
		end
		y.quo = {y.quo[acci_pkg::CYL_W-acci_pkg::BPS-1:0], qb};
		return y;
	endfunction

	logic [acci_pkg::HPC_W-1:0]  heads_eff;
	logic [acci_pkg::SPT_W-1:0]  spt_eff;
	logic [acci_pkg::PC_W-1:0]   per_cyl;
	logic                        accept;
	logic [acci_pkg::QCNT_W-1:0] credit_q;
	div_t                        entry;
	div_t                        div_s   [acci_pkg::DIV_STAGES];
	logic                        div_v_s [acci_pkg::DIV_STAGES];
	acci_pkg::req_t              req_s;
	logic                        req_v_s;
	div_t                        last_div;
	logic [acci_pkg::SPT_W-1:0]  r2;
	logic [acci_pkg::SPT_W:0]    t2;
	logic [acci_pkg::HPC_W-1:0]  hq;
	logic                        ge2;

	// A geometry value of zero behaves as one.
	assign heads_eff = (cfg.heads == '0) ? acci_pkg::HPC_W'(1) : cfg.heads;
	assign spt_eff   = (cfg.spt == '0) ? acci_pkg::SPT_W'(1) : cfg.spt;
	assign per_cyl   = acci_pkg::PC_W'(heads_eff) * acci_pkg::PC_W'(spt_eff);

	// Credits cover every request in the pipeline or waiting in the queue,
	// so the queue can never overflow.
	assign full   = (credit_q == acci_pkg::QCNT_W'(acci_pkg::QDEPTH));
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, q_pop})
				2'b10:   credit_q <= credit_q + acci_pkg::QCNT_W'(1);
				2'b01:   credit_q <= credit_q - acci_pkg::QCNT_W'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_comb begin
		entry.num   = acci_pkg::LBA_PAD'(block_address);
		entry.rem   = '0;
		entry.quo   = '0;
		entry.count = sector_count;
		entry.cmd   = command;
		if (command == cfg.read_op) begin
			entry.dir = acci_pkg::DIR_READ;
		end else if (command == cfg.write_op) begin
			entry.dir = acci_pkg::DIR_WRITE;
		end else begin
			entry.dir = acci_pkg::DIR_NONE;
		end
	end

	for (genvar k = 0; k < acci_pkg::DIV_STAGES; k++) begin : g_div
		div_t stg_in;
		logic stg_v;
		if (k == 0) begin : g_first
			assign stg_in = entry;
			assign stg_v  = accept;
		end else begin : g_next
			assign stg_in = div_s[k-1];
			assign stg_v  = div_v_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else begin
				div_v_s[k] <= stg_v;
			end
		end

		always_ff @(posedge clk) begin
			div_s[k] <= div_stage(stg_in, per_cyl);
		end
	end

	// Split the remainder into head and sector. The head is below the head
	// count, so only HPC_W quotient bits remain to be found.
	assign last_div = div_s[acci_pkg::DIV_STAGES-1];

	always_comb begin
		r2 = last_div.rem[acci_pkg::PC_W-1:acci_pkg::HPC_W];
		hq = '0;
		for (int i = acci_pkg::HPC_W - 1; i >= 0; i--) begin
			t2  = {r2, last_div.rem[i]};
			ge2 = (t2 >= {1'b0, spt_eff});
			if (ge2) begin
				t2 = t2 - {1'b0, spt_eff};
			end
			hq = {hq[acci_pkg::HPC_W-2:0], ge2};
			r2 = t2[acci_pkg::SPT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s <= 1'b0;
		end else begin
			req_v_s <= div_v_s[acci_pkg::DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		req_s.count <= last_div.count;
		req_s.cmd   <= last_div.cmd;
		req_s.dir   <= last_div.dir;
		req_s.cyl   <= last_div.quo;
		req_s.head  <= hq;
		req_s.sect  <= r2 + acci_pkg::SPT_W'(1);
	end

	assign req_valid = req_v_s;
	assign req       = req_s;

endmodule
`default_nettype wire

### rtl/acci_queue.sv
`default_nettype none
module acci_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire acci_pkg::req_t wr_data,
	input  wire logic           rd_en,
	output acci_pkg::req_t      rd_data,
	output logic                not_empty
);

	acci_pkg::req_t               mem_q [acci_pkg::QDEPTH];
	logic [acci_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [acci_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [acci_pkg::QCNT_W-1:0]  cnt_q;

	assign not_empty = (cnt_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + acci_pkg::QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + acci_pkg::QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + acci_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - acci_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/acci_back.sv
`default_nettype none
module acci_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_not_empty,
	input  wire acci_pkg::req_t q_data,
	output logic                q_pop,
	input  wire logic           pop,
	output logic                empty,
	output acci_pkg::wr_t       wr
);

	acci_pkg::req_t               cur_q;
	logic                         cur_valid_q;
	logic [acci_pkg::IDX_W-1:0]   idx_q;
	acci_pkg::wr_t                out_q;
	logic                         out_valid_q;
	acci_pkg::wr_t                nxt;
	logic                         advance;
	logic                         finishing;

	// The output slot frees up in the same cycle its transfer completes.
	assign advance   = cur_valid_q && (!out_valid_q || pop);
	assign finishing = advance && (idx_q == acci_pkg::REG_COMMAND);
	assign q_pop     = q_not_empty && (!cur_valid_q || finishing);

	always_comb begin
		nxt.idx    = idx_q;
		nxt.dir    = acci_pkg::DIR_NONE;
		nxt.dwords = '0;
		nxt.last   = 1'b0;
		case (idx_q)
			acci_pkg::REG_COUNT:    nxt.value = cur_q.count;
			acci_pkg::REG_SECTOR:   nxt.value = acci_pkg::VAL_W'(cur_q.sect);
			acci_pkg::REG_CYL_LOW:  nxt.value = cur_q.cyl[7:0];
			acci_pkg::REG_CYL_HIGH: nxt.value = cur_q.cyl[15:8];
			acci_pkg::REG_DRV_HEAD: begin
				nxt.value = acci_pkg::DRV_HEAD_BASE | acci_pkg::VAL_W'(cur_q.head);
			end
			acci_pkg::REG_COMMAND: begin
				nxt.value = cur_q.cmd;
				nxt.dir   = cur_q.dir;
				nxt.last  = 1'b1;
				if (cur_q.dir != acci_pkg::DIR_NONE) begin
					nxt.dwords = acci_pkg::DW_W'({cur_q.count, acci_pkg::DWORD_SHIFT'(0)});
				end
			end
			default: nxt.value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= acci_pkg::REG_COUNT;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= acci_pkg::REG_COUNT;
			end else if (finishing) begin
				cur_valid_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + acci_pkg::IDX_W'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (advance) begin
			out_q <= nxt;
		end
	end

	assign empty = !out_valid_q;
	assign wr    = out_q;

endmodule
`default_nettype wire

### rtl/ata_chs_command_issuer.sv
// The first task file write (count) follows the divider stages, the result register, the
// queue and the sequencer; the other five follow on consecutive cycles when pop is held
// high. The one result port carries six writes per request, so the sequencer takes a new
// request only as the last one reaches its command write; the pipelined divider takes a
// request every cycle while full is low, and up to 8 wait before the write sequencer.
// Reset: arst_n clears all control state at once; geometry and opcodes take their defaults.
`default_nettype none
module ata_chs_command_issuer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [acci_pkg::LBA_BITS-1:0]  block_address,
	input  wire logic [acci_pkg::COUNT_W-1:0]   sector_count,
	input  wire logic [acci_pkg::CMD_W-1:0]     command,
	output logic                                empty,
	input  wire logic                           pop,
	output logic      [acci_pkg::IDX_W-1:0]     reg_index,
	output logic      [acci_pkg::VAL_W-1:0]     reg_value,
	output logic      [acci_pkg::DIR_W-1:0]     transfer_dir,
	output logic      [acci_pkg::DW_W-1:0]      transfer_dwords,
	output logic                                last,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [acci_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [acci_pkg::PDATA_W-1:0]   pwdata,
	output logic      [acci_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready
);

	acci_pkg::cfg_t cfg;
	acci_pkg::req_t req;
	acci_pkg::req_t q_data;
	acci_pkg::wr_t  wr;
	logic           req_valid;
	logic           q_pop;
	logic           q_not_empty;

	acci_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acci_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.block_address (block_address),
		.sector_count  (sector_count),
		.command       (command),
		.cfg           (cfg),
		.q_pop         (q_pop),
		.req_valid     (req_valid),
		.req           (req)
	);

	acci_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (req_valid),
		.wr_data   (req),
		.rd_en     (q_pop),
		.rd_data   (q_data),
		.not_empty (q_not_empty)
	);

	acci_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.wr          (wr)
	);

	assign reg_index       = wr.idx;
	assign reg_value       = wr.value;
	assign transfer_dir    = wr.dir;
	assign transfer_dwords = wr.dwords;
	assign last            = wr.last;

endmodule
`default_nettype wire

### rtl/acci_checker.sv
`default_nettype none
module acci_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         empty,
	input wire logic                         pop,
	input wire logic [acci_pkg::IDX_W-1:0]   reg_index,
	input wire logic [acci_pkg::VAL_W-1:0]   reg_value,
	input wire logic [acci_pkg::DIR_W-1:0]   transfer_dir,
	input wire logic [acci_pkg::DW_W-1:0]    transfer_dwords,
	input wire logic                         last
);

	// The command write and only the command write closes a run.
	a_last_is_command: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (reg_index == acci_pkg::REG_COMMAND)))
		else $error("last flag does not match the command register write");

	// Within a run, the next write is ready right after each transfer.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=>
			(!empty && (reg_index == $past(reg_index) + acci_pkg::IDX_W'(1))))
		else $error("task file writes of one request are not back to back");

	// Transfer information appears only on the command write.
	a_side_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (!last || transfer_dir == acci_pkg::DIR_NONE)) |->
			(transfer_dwords == '0 && (last || transfer_dir == acci_pkg::DIR_NONE)))
		else $error("transfer fields set outside a command transfer");

	// A waiting write holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(reg_index) && $stable(reg_value)))
		else $error("waiting write changed before its transfer");

endmodule

bind ata_chs_command_issuer acci_checker u_acci_checker (.*);
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
module tb_top;
	import acci_pkg::*;

	class task_file_board;
		logic [HPC_W-1:0] heads;
		logic [SPT_W-1:0] spt;
		logic [CMD_W-1:0] read_op;
		logic [CMD_W-1:0] write_op;
		wr_t expected_writes[$];
		int errors;

		function new();
			heads = HEADS_RST;
			spt = SPT_RST;
			read_op = READ_OP_RST;
			write_op = WRITE_OP_RST;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
			case (idx)
				CFG_HEADS: heads = value[HPC_W-1:0];
				CFG_SPT: spt = value[SPT_W-1:0];
				CFG_READ_OP: read_op = value[CMD_W-1:0];
				CFG_WRITE_OP: write_op = value[CMD_W-1:0];
				default: ;
			endcase
		endfunction

		// A geometry field of zero behaves as one.
		function int unsigned cylinder_size();
			int unsigned h;
			int unsigned s;
			h = (heads == 0) ? 1 : heads;
			s = (spt == 0) ? 1 : spt;
			return h * s;
		endfunction

		function wr_t file_write(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] value,
				logic [DIR_W-1:0] dir, logic [DW_W-1:0] dwords, logic is_last);
			wr_t w;
			w.idx = idx;
			w.value = value;
			w.dir = dir;
			w.dwords = dwords;
			w.last = is_last;
			return w;
		endfunction

		function void predict_task_file_writes(logic [LBA_BITS-1:0] lba,
				logic [COUNT_W-1:0] count, logic [CMD_W-1:0] cmd);
			int unsigned s;
			int unsigned per_cyl;
			int unsigned cyl;
			int unsigned rem;
			int unsigned head;
			int unsigned sect;
			logic [DIR_W-1:0] dir;
			logic [DW_W-1:0] dwords;
			s = (spt == 0) ? 1 : spt;
			per_cyl = cylinder_size();
			cyl = lba / per_cyl;
			rem = lba % per_cyl;
			head = rem / s;
			sect = rem % s + 1;
			// A read match wins when both opcodes are the same.
			if (cmd == read_op)
				dir = DIR_READ;
			else if (cmd == write_op)
				dir = DIR_WRITE;
			else
				dir = DIR_NONE;
			dwords = (dir == DIR_NONE) ? '0 : DW_W'({count, 7'b0});
			expected_writes.push_back(file_write(REG_COUNT, count, DIR_NONE, '0, 1'b0));
			expected_writes.push_back(file_write(REG_SECTOR, VAL_W'(sect), DIR_NONE, '0, 1'b0));
			expected_writes.push_back(file_write(REG_CYL_LOW, cyl[7:0], DIR_NONE, '0, 1'b0));
			expected_writes.push_back(file_write(REG_CYL_HIGH, cyl[15:8], DIR_NONE, '0, 1'b0));
			expected_writes.push_back(file_write(REG_DRV_HEAD, DRV_HEAD_BASE | VAL_W'(head),
				DIR_NONE, '0, 1'b0));
			expected_writes.push_back(file_write(REG_COMMAND, cmd, dir, dwords, 1'b1));
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH: %s", msg);
		endtask

		task check_write(wr_t got);
			wr_t want;
			if (expected_writes.size() == 0) begin
				report($sformatf("unexpected write to register %0d value %02h",
					got.idx, got.value));
				return;
			end
			want = expected_writes.pop_front();
			if (got.idx !== want.idx)
				report($sformatf("reg_index %0d, wanted %0d", got.idx, want.idx));
			if (got.value !== want.value)
				report($sformatf("reg_value %02h, wanted %02h (register %0d)",
					got.value, want.value, want.idx));
			if (got.dir !== want.dir)
				report($sformatf("transfer_dir %0d, wanted %0d (register %0d)",
					got.dir, want.dir, want.idx));
			if (got.dwords !== want.dwords)
				report($sformatf("transfer_dwords %0d, wanted %0d (register %0d)",
					got.dwords, want.dwords, want.idx));
			if (got.last !== want.last)
				report($sformatf("last %0b, wanted %0b (register %0d)",
					got.last, want.last, want.idx));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [LBA_BITS-1:0] block_address;
	logic [COUNT_W-1:0] sector_count;
	logic [CMD_W-1:0] command;
	logic empty;
	logic pop = 1'b0;
	logic [IDX_W-1:0] reg_index;
	logic [VAL_W-1:0] reg_value;
	logic [DIR_W-1:0] transfer_dir;
	logic [DW_W-1:0] transfer_dwords;
	logic last;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// Both sides stop idling while this is set.
	bit steady = 1'b0;
	task_file_board board = new();

	ata_chs_command_issuer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.block_address(block_address),
		.sector_count(sector_count),
		.command(command),
		.empty(empty),
		.pop(pop),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.transfer_dir(transfer_dir),
		.transfer_dwords(transfer_dwords),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		pop <= steady || ($urandom_range(0, 99) >= 28);
	end

	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0)
			board.check_write(board.file_write(reg_index, reg_value, transfer_dir,
				transfer_dwords, last));
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task send_request(logic [LBA_BITS-1:0] lba, logic [COUNT_W-1:0] count,
			logic [CMD_W-1:0] cmd);
		while (!steady && $urandom_range(0, 99) < 28) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		block_address <= lba;
		sector_count <= count;
		command <= cmd;
		do @(posedge clk); while (full !== 1'b0);
		board.predict_task_file_writes(lba, count, cmd);
		@(negedge clk);
	endtask

	task write_register(logic [CFG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task configure(int h, int s, int rd, int wr);
		write_register(CFG_HEADS, h);
		write_register(CFG_SPT, s);
		write_register(CFG_READ_OP, rd);
		write_register(CFG_WRITE_OP, wr);
	endtask

	task drain_writes();
		push <= 1'b0;
		while (board.expected_writes.size() != 0)
			@(negedge clk);
	endtask

	function logic [LBA_BITS-1:0] random_lba();
		int unsigned per_cyl;
		int unsigned k;
		per_cyl = board.cylinder_size();
		case ($urandom_range(0, 3))
			0: return LBA_BITS'($urandom());
			1: return LBA_BITS'($urandom_range(0, 4095));
			2: begin
				// Land on or next to a cylinder boundary.
				k = $urandom_range(0, (28'hFFFFFFF / per_cyl));
				return LBA_BITS'(k * per_cyl + $urandom_range(0, 2) - 1);
			end
			default: return 28'hFFFFFFF - LBA_BITS'($urandom_range(0, 255));
		endcase
	endfunction

	task random_requests(int n);
		logic [COUNT_W-1:0] count;
		logic [CMD_W-1:0] cmd;
		int r;
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				count = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			else
				count = COUNT_W'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < 35)
				cmd = board.read_op;
			else if (r < 70)
				cmd = board.write_op;
			else
				cmd = CMD_W'($urandom_range(0, 255));
			send_request(random_lba(), count, cmd);
		end
	endtask

	initial begin
		int rd;
		arst_n = 1'b0;
		push = 1'b0;
		block_address = '0;
		sector_count = '0;
		command = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset geometry: 16 heads, 63 sectors, read 0x20, write 0x30.
		send_request(28'd0, 8'd0, 8'h20);
		send_request(28'hFFFFFFF, 8'd255, 8'h30);
		send_request(28'd1007, 8'd1, 8'h20);
		send_request(28'd1008, 8'd128, 8'h30);
		send_request(28'd66059280, 8'd1, 8'hFF);
		send_request(28'd66060288, 8'd2, 8'h00);
		send_request(28'd63, 8'd7, 8'h21);
		send_request(28'h5555555, 8'hAA, 8'h20);
		send_request(28'hAAAAAAA, 8'h55, 8'h30);
		drain_writes();

		// Zero geometry and equal opcodes.
		configure(0, 0, 8'hC4, 8'hC4);
		send_request(28'hFFFFFFF, 8'd255, 8'hC4);
		send_request(28'd12345, 8'd3, 8'hC4);
		send_request(28'd0, 8'd1, 8'h00);
		drain_writes();

		// Head numbers of 16 and above spill into the upper drive/head bits.
		configure(31, 63, 8'h25, 8'h35);
		send_request(28'd1260, 8'd4, 8'h25);
		send_request(28'd1952, 8'd9, 8'h35);
		send_request(28'd1013, 8'd0, 8'h00);
		send_request(28'hFFFFFFF, 8'd255, 8'h35);
		drain_writes();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: configure(1, 1, 8'h00, 8'hFF);
				1: configure(16, 63, 8'h20, 8'h30);
				2: configure(0, 63, 8'hFF, 8'h00);
				3: configure(31, 0, $urandom_range(0, 255), $urandom_range(0, 255));
				default: begin
					rd = $urandom_range(0, 255);
					configure($urandom_range(0, 31), $urandom_range(0, 63), rd,
						($urandom_range(0, 3) == 0) ? rd : $urandom_range(0, 255));
				end
			endcase
			steady = (phase == 1);
			random_requests(66);
			drain_writes();
		end
		steady = 1'b0;

		repeat (40) @(negedge clk);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
rtl/acci_pkg.sv
rtl/acci_regs.sv
rtl/acci_front.sv
rtl/acci_queue.sv
rtl/acci_back.sv
rtl/ata_chs_command_issuer.sv
rtl/acci_checker.sv
verif/tb_top.sv
